FILE: hw/rtl/piecewise_linear_charge_lookup_defines.svh
// assertion helpers used by the lookup rtl back end
`ifndef PIECEWISE_LINEAR_CHARGE_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_CHARGE_LOOKUP_DEFINES_SVH

// plain property, checked on clk_i, off while rst_ni is low
`define PLCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PLCL_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PLCL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/plcl_pkg.sv
package plcl_pkg;

  // field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned REGION_W  = 2;
  localparam int unsigned APB_W     = 32;

  // table geometry
  localparam int unsigned TABLE_SLOTS        = 4;
  localparam int unsigned SLOT_W             = 2;
  localparam int unsigned REG_IDX_W          = SLOT_W + 1;
  localparam int unsigned ADDR_W             = REG_IDX_W + 2;
  localparam int unsigned NUM_POINTS_DEFAULT = 4;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // charge values
  localparam logic [DATA_W-1:0] CHARGE_FULL  = 16'd32768;
  localparam logic [DATA_W-1:0] CHARGE_EMPTY = 16'd0;

  // register reset values, slot 0 in the low bits
  localparam logic [TABLE_SLOTS-1:0][DATA_W-1:0] VOLT_RESET =
    {16'd16000, 16'd16000, 16'd15100, 16'd14200};
  localparam logic [TABLE_SLOTS-1:0][DATA_W-1:0] CHARGE_RESET =
    {16'd32768, 16'd32768, 16'd16384, 16'd6554};

  typedef enum logic [REGION_W-1:0] {
    REGION_INTERP = 2'd0,
    REGION_FULL   = 2'd1,
    REGION_EMPTY  = 2'd2
  } region_e;

  // breakpoint table as seen by the front
  typedef struct packed {
    logic [TABLE_SLOTS-1:0][DATA_W-1:0] volt;
    logic [TABLE_SLOTS-1:0][DATA_W-1:0] charge;
  } table_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] dc_mag;
    logic              dc_neg;
    logic [DATA_W-1:0] dv;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] c_base;
    region_e           region;
  } job_t;

endpackage

FILE: hw/rtl/plcl_sample_if.sv
interface plcl_sample_if;
  logic                        valid;
  logic                        ready;
  logic [plcl_pkg::DATA_W-1:0] sample_voltage;

  modport source (output valid, output sample_voltage, input ready);
  modport sink   (input valid, input sample_voltage, output ready);
endinterface

FILE: hw/rtl/plcl_result_if.sv
interface plcl_result_if;
  logic                          valid;
  logic                          ready;
  logic [plcl_pkg::DATA_W-1:0]   charge_level;
  logic [plcl_pkg::REGION_W-1:0] region;

  modport source (output valid, output charge_level, output region, input ready);
  modport sink   (input valid, input charge_level, input region, output ready);
endinterface

FILE: hw/rtl/plcl_regs.sv
module plcl_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plcl_pkg::ADDR_W-1:0]     paddr,
  input  logic [plcl_pkg::APB_W-1:0]      pwdata,
  output logic [plcl_pkg::APB_W-1:0]      prdata,
  output logic                            pready,
  output plcl_pkg::table_t                table_o
);

  localparam int unsigned W = plcl_pkg::DATA_W;

  logic [plcl_pkg::TABLE_SLOTS-1:0][W-1:0] volt_q;
  logic [plcl_pkg::TABLE_SLOTS-1:0][W-1:0] charge_q;
  logic [plcl_pkg::REG_IDX_W-1:0]          reg_idx;
  logic [plcl_pkg::SLOT_W-1:0]             slot;
  logic                                    charge_bank;
  logic                                    wr_en;

  // word address decode: top index bit picks the charge bank
  assign reg_idx     = paddr[plcl_pkg::ADDR_W-1:2];
  assign slot        = reg_idx[plcl_pkg::SLOT_W-1:0];
  assign charge_bank = reg_idx[plcl_pkg::REG_IDX_W-1];
  assign wr_en       = psel && penable && pwrite;
  assign pready      = 1'b1;

  // breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_q   <= plcl_pkg::VOLT_RESET;
      charge_q <= plcl_pkg::CHARGE_RESET;
    end else if (wr_en) begin
      if (charge_bank) begin
        charge_q[slot] <= pwdata[W-1:0];
      end else begin
        volt_q[slot] <= pwdata[W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    prdata[W-1:0] = charge_bank ? charge_q[slot] : volt_q[slot];
  end

  assign table_o.volt   = volt_q;
  assign table_o.charge = charge_q;

endmodule

FILE: hw/rtl/plcl_front.sv
module plcl_front #(
  parameter int unsigned NUM_POINTS = plcl_pkg::NUM_POINTS_DEFAULT
) (
  plcl_sample_if.sink      sample_i,
  input  plcl_pkg::table_t table_i,
  input  logic             full_i,
  output logic             push_o,
  output plcl_pkg::job_t   job_o
);

  localparam int unsigned W = plcl_pkg::DATA_W;

  logic [plcl_pkg::TABLE_SLOTS-1:0] hit;
  logic                             found;
  logic [W:0]                       dc;

  // take a beat whenever the queue has room
  assign sample_i.ready = !full_i;
  assign push_o         = sample_i.valid && !full_i;

  // compare the sample against every used breakpoint
  always_comb begin
    hit = '0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      hit[i] = table_i.volt[i] >= sample_i.sample_voltage;
    end
  end

  // pick the first hit and set up the interpolation operands
  always_comb begin
    found = 1'b0;
    dc    = '0;
    // default: above the table, reported as full with a zero step
    job_o.region = plcl_pkg::REGION_FULL;
    job_o.c_base = plcl_pkg::CHARGE_FULL;
    job_o.dv     = '0;
    job_o.den    = W'(1);
    job_o.dc_mag = '0;
    job_o.dc_neg = 1'b0;
    if (hit[0]) begin
      job_o.region = plcl_pkg::REGION_EMPTY;
      job_o.c_base = plcl_pkg::CHARGE_EMPTY;
    end else begin
      for (int i = 1; i < NUM_POINTS; i++) begin
        if (!found && hit[i]) begin
          found        = 1'b1;
          dc           = {1'b0, table_i.charge[i]} - {1'b0, table_i.charge[i-1]};
          job_o.region = plcl_pkg::REGION_INTERP;
          job_o.c_base = table_i.charge[i-1];
          job_o.dv     = sample_i.sample_voltage - table_i.volt[i-1];
          job_o.den    = table_i.volt[i] - table_i.volt[i-1];
          job_o.dc_neg = dc[W];
          job_o.dc_mag = dc[W] ? W'(-dc) : dc[W-1:0];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/plcl_queue.sv
module plcl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  plcl_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output plcl_pkg::job_t job_o
);

  localparam int unsigned DEPTH = plcl_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  plcl_pkg::job_t data_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = count_q == CW'(DEPTH);
  assign empty_o = count_q == '0;
  assign job_o   = data_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: hw/rtl/plcl_back.sv
`include "piecewise_linear_charge_lookup_defines.svh"

module plcl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  plcl_pkg::job_t   job_i,
  output logic             pop_o,
  plcl_result_if.source    result_o
);

  localparam int unsigned W          = plcl_pkg::DATA_W;
  localparam int unsigned DIV_STAGES = W;

  typedef struct packed {
    logic [W-1:0]      rem;
    logic [W-1:0]      low;
    logic [W-1:0]      quo;
    logic [W-1:0]      den;
    logic [W-1:0]      c_base;
    logic              neg;
    plcl_pkg::region_e region;
  } stage_t;

  // one restoring divide step: shift in a dividend bit, subtract if it fits
  function automatic stage_t div_step(stage_t s);
    logic [W:0] trial;
    stage_t     r;
    r     = s;
    trial = {s.rem, s.low[W-1]};
    r.low = {s.low[W-2:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      r.rem = W'(trial - {1'b0, s.den});
      r.quo = {s.quo[W-2:0], 1'b1};
    end else begin
      r.rem = trial[W-1:0];
      r.quo = {s.quo[W-2:0], 1'b0};
    end
    return r;
  endfunction

  stage_t              stage_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] valid_q;
  stage_t              mul_d;
  logic [2*W-1:0]      prod;
  logic                adv;
  logic                out_valid_q;
  logic [W-1:0]        charge_q;
  plcl_pkg::region_e   region_q;
  logic [W+1:0]        sum;
  logic [W-1:0]        charge_d;
  stage_t              last;
  logic                last_vld;
  logic                edge_vld;
  logic                out_full;
  logic                out_empty;

  // whole pipeline moves whenever the output register can take a beat
  assign adv   = !out_valid_q || result_o.ready;
  assign pop_o = adv && !empty_i;

  // product of step and offset; upper half is below the divisor
  always_comb begin
    prod         = job_i.dc_mag * job_i.dv;
    mul_d.rem    = prod[2*W-1:W];
    mul_d.low    = prod[W-1:0];
    mul_d.quo    = '0;
    mul_d.den    = job_i.den;
    mul_d.c_base = job_i.c_base;
    mul_d.neg    = job_i.dc_neg;
    mul_d.region = job_i.region;
  end

  // apply the sign of the step to the quotient, clamp to the field range
  assign last = stage_q[DIV_STAGES];
  always_comb begin
    if (last.neg) begin
      sum = {2'b00, last.c_base} - {2'b00, last.quo};
    end else begin
      sum = {2'b00, last.c_base} + {2'b00, last.quo};
    end
    if (sum[W+1]) begin
      charge_d = '0;
    end else if (sum[W]) begin
      charge_d = '1;
    end else begin
      charge_d = sum[W-1:0];
    end
  end

  // stage valids and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[DIV_STAGES-1:0], pop_o};
      out_valid_q <= valid_q[DIV_STAGES];
    end
  end

  // multiply stage, divide stages and output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage_q[0] <= mul_d;
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage_q[k+1] <= div_step(stage_q[k]);
      end
      charge_q <= charge_d;
      region_q <= last.region;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.charge_level = charge_q;
  assign result_o.region       = region_q;

  // shorthands for the checks below
  assign last_vld  = valid_q[DIV_STAGES];
  assign edge_vld  = last_vld && last.region != plcl_pkg::REGION_INTERP;
  assign out_full  = out_valid_q && region_q == plcl_pkg::REGION_FULL;
  assign out_empty = out_valid_q && region_q == plcl_pkg::REGION_EMPTY;

  `PLCL_ASSERT_IMPL(a_rem_below_den, last_vld, last.rem < last.den, "remainder not below divisor")
  `PLCL_ASSERT_IMPL(a_edge_zero_quo, edge_vld, last.quo == '0, "quotient set outside interpolation")
  `PLCL_ASSERT_IMPL(a_full_value, out_full, charge_q == plcl_pkg::CHARGE_FULL, "bad full charge")
  `PLCL_ASSERT_IMPL(a_empty_val, out_empty, charge_q == plcl_pkg::CHARGE_EMPTY, "bad empty charge")

endmodule

FILE: hw/rtl/piecewise_linear_charge_lookup.sv
// channel     dir  beat fields                      handshake
// sample_i    in   sample_voltage[15:0]             valid / ready
// result_o    out  charge_level[15:0], region[1:0]  valid / ready
// apb         in   paddr[4:0], pwdata, prdata       psel / penable / pready
//
// one sample per clock sustained unless result_o stalls; results pass through
// queue slot, multiply, 16 pipelined restoring divide steps and output register
// rst_ni is asynchronous active low; table registers reset to their defaults
// a stalled result_o freezes the back pipeline; the 4-entry queue keeps
// taking samples until it fills, then sample_i.ready drops

module piecewise_linear_charge_lookup #(
  parameter int unsigned NUM_POINTS = plcl_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  plcl_sample_if.sink                 sample_i,
  plcl_result_if.source               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plcl_pkg::ADDR_W-1:0] paddr,
  input  logic [plcl_pkg::APB_W-1:0]  pwdata,
  output logic [plcl_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);

  plcl_pkg::table_t tbl;
  plcl_pkg::job_t   push_job, pop_job;
  logic             push, pop, full, empty;

  // configuration registers
  plcl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .table_o (tbl)
  );

  // segment search and operand setup
  plcl_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .sample_i (sample_i),
    .table_i  (tbl),
    .full_i   (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // job queue
  plcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (pop_job)
  );

  // multiply, divide and result
  plcl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .job_i    (pop_job),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

FILE: test/piecewise_linear_charge_lookup_test.sv
`timescale 1ns / 1ps

module piecewise_linear_charge_lookup_test;
  import plcl_pkg::*;

  localparam int unsigned LOOKUP_POINTS       = NUM_POINTS_DEFAULT;
  localparam int unsigned CLK_PERIOD          = 8;
  localparam int unsigned RESET_CYCLES        = 9;
  localparam int unsigned PIPE_LATENCY        = 19;
  localparam int unsigned RANDOM_PER_PHASE    = 65;
  localparam int unsigned MAX_PRINTED         = 100;
  localparam int unsigned REG_POINT_VOLTAGE_0 = 0;
  localparam int unsigned REG_POINT_CHARGE_0  = 4;

  typedef logic [TABLE_SLOTS-1:0][DATA_W-1:0] point_row_t;

  typedef struct {
    logic [DATA_W-1:0] charge;
    region_e           region;
  } charge_beat_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  plcl_sample_if sample_bus ();
  plcl_result_if result_bus ();

  piecewise_linear_charge_lookup #(
    .NUM_POINTS(LOOKUP_POINTS)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the breakpoint table, slot 0 in the low bits
  point_row_t volt_table   = VOLT_RESET;
  point_row_t charge_table = CHARGE_RESET;

  logic [DATA_W-1:0] pending_samples[$];
  charge_beat_t      charge_expect[$];
  int unsigned       samples_queued   = 0;
  int unsigned       samples_accepted = 0;
  int unsigned       mismatch_count   = 0;
  int unsigned       send_idle_pct    = 0;
  int unsigned       recv_idle_pct    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // expected charge and region for one voltage sample
  function automatic charge_beat_t lookup_charge(input logic [DATA_W-1:0] volt);
    charge_beat_t beat;
    int           sel;
    longint       v_lo;
    longint       v_hi;
    longint       c_lo;
    longint       c_hi;
    longint       level;
    sel = -1;
    for (int i = 0; i < LOOKUP_POINTS; i++) begin
      if (sel < 0 && volt_table[i] >= volt) sel = i;
    end
    if (sel < 0) begin
      beat.charge = CHARGE_FULL;
      beat.region = REGION_FULL;
    end else if (sel == 0) begin
      beat.charge = CHARGE_EMPTY;
      beat.region = REGION_EMPTY;
    end else begin
      v_lo  = volt_table[sel-1];
      v_hi  = volt_table[sel];
      c_lo  = charge_table[sel-1];
      c_hi  = charge_table[sel];
      // signed division truncates toward zero
      level = c_lo + ((c_hi - c_lo) * (longint'(volt) - v_lo)) / (v_hi - v_lo);
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      beat.charge = level[DATA_W-1:0];
      beat.region = REGION_INTERP;
    end
    return beat;
  endfunction

  // mostly samples inside or near the table, some anywhere
  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned slot;
    int unsigned other;
    int          near;
    slot  = $urandom_range(0, LOOKUP_POINTS - 1);
    other = (slot + 1) % LOOKUP_POINTS;
    case ($urandom_range(0, 9))
      0, 1: begin
        return DATA_W'($urandom);
      end
      2, 3, 4: begin
        near = int'(volt_table[slot]) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return DATA_W'(near);
      end
      default: begin
        return DATA_W'($urandom_range(volt_table[slot], volt_table[other]));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic queue_sample(input logic [DATA_W-1:0] volt);
    pending_samples.push_back(volt);
    samples_queued++;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_sample(pick_sample());
  endtask

  // wait until every sample went in and every result came out
  task automatic drain_all();
    while (samples_accepted != samples_queued || charge_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // apb write, leaves psel high so writes can run back to back
  task automatic write_register(input int unsigned index, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(index * 4);
    pwdata  <= APB_W'({$urandom, value});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (index < REG_POINT_CHARGE_0) volt_table[index - REG_POINT_VOLTAGE_0] = value;
    else charge_table[index - REG_POINT_CHARGE_0] = value;
  endtask

  task automatic load_table(input point_row_t volts, input point_row_t charges);
    @(posedge clk_i);
    for (int i = 0; i < TABLE_SLOTS; i++) write_register(REG_POINT_VOLTAGE_0 + i, volts[i]);
    for (int i = 0; i < TABLE_SLOTS; i++) write_register(REG_POINT_CHARGE_0 + i, charges[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sample driver, predicts each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_bus.valid          <= 1'b0;
      sample_bus.sample_voltage <= '0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        charge_expect.push_back(lookup_charge(sample_bus.sample_voltage));
        samples_accepted++;
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample_bus.valid          <= 1'b1;
          sample_bus.sample_voltage <= pending_samples.pop_front();
        end else begin
          sample_bus.valid          <= 1'b0;
          sample_bus.sample_voltage <= DATA_W'($urandom);
        end
      end
    end
  end

  // result monitor with random back pressure
  always @(posedge clk_i) begin : result_monitor
    charge_beat_t due_beat;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (charge_expect.size() == 0) begin
          report_mismatch($sformatf("result with no pending sample: charge %0d region %0d",
                                    result_bus.charge_level, result_bus.region));
        end else begin
          due_beat = charge_expect.pop_front();
          if (result_bus.charge_level !== due_beat.charge) begin
            report_mismatch($sformatf("charge_level %0d, predicted %0d",
                                      result_bus.charge_level, due_beat.charge));
          end
          if (result_bus.region !== due_beat.region) begin
            report_mismatch($sformatf("region %0d, predicted %0d",
                                      result_bus.region, due_beat.region));
          end
        end
      end
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // stimulus sequence
  initial begin
    point_row_t  rand_volts;
    point_row_t  rand_charges;
    int unsigned volt_acc;

    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 83;

    // reset table: field extremes, exact breakpoints and their neighbors
    queue_sample(16'd0);     queue_sample(16'd65535); queue_sample(16'd1);
    queue_sample(16'd65534); queue_sample(16'd14199); queue_sample(16'd14200);
    queue_sample(16'd14201); queue_sample(16'd15099); queue_sample(16'd15100);
    queue_sample(16'd15101); queue_sample(16'd15550); queue_sample(16'd15999);
    queue_sample(16'd16000); queue_sample(16'd16001); queue_sample(16'hAAAA);
    queue_sample(16'h5555);
    drain_all();

    // extreme table, slot 3 first
    load_table({16'd65535, 16'd65535, 16'd0, 16'd0},
               {16'd65535, 16'd65535, 16'd0, 16'd0});
    queue_sample(16'd0);     queue_sample(16'd1);     queue_sample(16'd32767);
    queue_sample(16'd65534); queue_sample(16'd65535);
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    // unsorted voltages, falling charges and charges above full
    load_table({16'd60000, 16'd20000, 16'd40000, 16'd10000},
               {16'd100, 16'd60000, 16'd5000, 16'd30000});
    queue_sample(16'd9999);  queue_sample(16'd10000); queue_sample(16'd10001);
    queue_sample(16'd25000); queue_sample(16'd40001); queue_sample(16'd50000);
    queue_sample(16'd60001);
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    // now the receiver idles lightly, sender heavily
    send_idle_pct = 83;
    recv_idle_pct = 25;

    // two points used, last breakpoint repeated
    load_table({16'd3000, 16'd3000, 16'd3000, 16'd1000},
               {16'd32768, 16'd32768, 16'd32768, 16'd0});
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    // random ascending table
    volt_acc = $urandom_range(0, 16000);
    rand_volts[0] = DATA_W'(volt_acc);
    for (int i = 1; i < TABLE_SLOTS; i++) begin
      volt_acc += $urandom_range(1, 16000);
      rand_volts[i] = DATA_W'(volt_acc);
    end
    for (int i = 0; i < TABLE_SLOTS; i++) rand_charges[i] = DATA_W'($urandom_range(0, 32768));
    load_table(rand_volts, rand_charges);
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // fully random table, any order, any charge
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rand_volts[i]   = DATA_W'($urandom);
      rand_charges[i] = DATA_W'($urandom);
    end
    load_table(rand_volts, rand_charges);
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    // steep first segment, widest second segment
    load_table({16'd65535, 16'd65534, 16'd101, 16'd100},
               {16'd32768, 16'd0, 16'd65535, 16'd0});
    queue_sample(16'd100);   queue_sample(16'd101);   queue_sample(16'd102);
    queue_sample(16'd30000); queue_sample(16'd65534); queue_sample(16'd65535);
    queue_random(RANDOM_PER_PHASE);
    drain_all();

    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (charge_expect.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", charge_expect.size()));
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/plcl_pkg.sv
hw/rtl/plcl_sample_if.sv
hw/rtl/plcl_result_if.sv
hw/rtl/plcl_regs.sv
hw/rtl/plcl_front.sv
hw/rtl/plcl_queue.sv
hw/rtl/plcl_back.sv
hw/rtl/piecewise_linear_charge_lookup.sv
test/piecewise_linear_charge_lookup_test.sv
